// ===== rtl/assert_macros.svh =====
// Assertion macros used by the sequencer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/i2cms_pkg.sv =====
// Types, codes and constants of the I2C master line sequencer.
package i2cms_pkg;

  // Command codes as carried in func; zero is a tick.
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_RACK  = 3'd5,
    CMD_SACK  = 3'd6
  } cmd_t;

  localparam logic [2:0] FUNC_TICK = 3'd0;

  // Class of an item as sorted by the front end.
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_TICK,
    CLS_CMD
  } cls_t;

  localparam int CFG_WIDTH = 16;
  localparam logic [CFG_WIDTH-1:0] HOLD_RESET = 16'd10;
  localparam logic [1:0] REG_HOLD_TICKS = 2'd0;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic       ack_to_send;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } out_word_t;

  // Classified word passed from the front end to the back end.
  typedef struct packed {
    cls_t       cls;
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       ack_to_send;
    logic       sda_in;
  } op_word_t;

  // Number of pin-change steps of each command.
  function automatic logic [4:0] step_total(cmd_t cmd);
    logic [4:0] total;
    unique case (cmd)
      CMD_START: total = 5'd4;
      CMD_STOP:  total = 5'd3;
      CMD_WRITE: total = 5'd24;
      CMD_READ:  total = 5'd17;
      CMD_RACK:  total = 5'd3;
      CMD_SACK:  total = 5'd3;
      default:   total = 5'd0;
    endcase
    return total;
  endfunction

endpackage

// ===== rtl/i2cms_queue.sv =====
// Two-entry word queue in flip-flops with push/full and pop/empty sides.
module i2cms_queue #(
  parameter type word_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  word_t wdata,
  input  logic  pop,
  output logic  empty,
  output word_t rdata
);
  import i2cms_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  word_t            store [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CntW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/i2cms_front.sv =====
// Front end: accepts input words, sorts them into tick, command or none, and queues them.
module i2cms_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  i2cms_pkg::in_word_t item,
  output i2cms_pkg::op_word_t op,
  output logic                op_empty,
  input  logic                op_pop
);
  import i2cms_pkg::*;

  op_word_t op_in;

  // Classify the function code
  always_comb begin
    op_in.data_byte   = item.data_byte;
    op_in.ack_to_send = item.ack_to_send;
    op_in.sda_in      = item.sda_in;
    op_in.cmd         = CMD_IDLE;
    unique case (item.func) inside
      FUNC_TICK: begin
        op_in.cls = CLS_TICK;
      end
      CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_RACK, CMD_SACK: begin
        op_in.cls = CLS_CMD;
        op_in.cmd = cmd_t'(item.func);
      end
      default: begin
        op_in.cls = CLS_NONE;
      end
    endcase
  end

  // Hold classified words until the back end takes them
  i2cms_queue #(
    .word_t(op_word_t)
  ) u_op_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .wdata(op_in),
    .pop  (op_pop),
    .empty(op_empty),
    .rdata(op)
  );

endmodule

// ===== rtl/i2cms_back.sv =====
// Back end: runs the line step sequence of each command and queues one result per word.
`include "assert_macros.svh"

module i2cms_back #(
  parameter int HOLD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [i2cms_pkg::CFG_WIDTH-1:0]     hold_ticks,
  input  i2cms_pkg::op_word_t                 op,
  input  logic                                op_empty,
  output logic                                op_pop,
  output i2cms_pkg::out_word_t                res,
  output logic                                res_empty,
  input  logic                                res_pop
);
  import i2cms_pkg::*;

  localparam int LoadBits = (HOLD_WIDTH < CFG_WIDTH) ? HOLD_WIDTH : CFG_WIDTH;

  logic                  scl_level, scl_level_next;
  logic                  sda_level, sda_level_next;
  cmd_t                  active_cmd, active_cmd_next;
  logic [4:0]            step_idx, step_idx_next;
  logic [1:0]            phase, phase_next;
  logic [2:0]            bit_idx, bit_idx_next;
  logic [HOLD_WIDTH-1:0] hold_cnt, hold_cnt_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [7:0]            rx_byte_q, rx_byte_q_next;
  logic                  ack_bit, ack_bit_next;

  logic                  take;
  logic                  done;
  logic                  res_full;
  logic [HOLD_WIDTH-1:0] hold_cut;
  logic [HOLD_WIDTH-1:0] hold_load;
  logic [HOLD_WIDTH-1:0] cnt_dec;
  logic [4:0]            step_inc;
  out_word_t             res_in;

  // Cut the hold setting to the counter width; zero acts as one
  assign hold_cut  = HOLD_WIDTH'(hold_ticks[LoadBits-1:0]);
  assign hold_load = (hold_cut == '0) ? HOLD_WIDTH'(1) : hold_cut;

  assign take   = !op_empty && !res_full;
  assign op_pop = take;

  // Sequencer next state
  always_comb begin
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    active_cmd_next = active_cmd;
    step_idx_next   = step_idx;
    phase_next      = phase;
    bit_idx_next    = bit_idx;
    hold_cnt_next   = hold_cnt;
    shift_byte_next = shift_byte;
    rx_byte_q_next  = rx_byte_q;
    ack_bit_next    = ack_bit;
    done            = 1'b0;
    cnt_dec         = (hold_cnt != '0) ? hold_cnt - 1'b1 : hold_cnt;
    step_inc        = step_idx + 5'd1;

    if (take) begin
      if (active_cmd == CMD_IDLE) begin
        // Start a command: load operands and apply its first step
        if (op.cls == CLS_CMD) begin
          active_cmd_next = op.cmd;
          step_idx_next   = '0;
          phase_next      = '0;
          bit_idx_next    = '0;
          hold_cnt_next   = hold_load;
          unique case (op.cmd)
            CMD_START: begin
              sda_level_next = 1'b1;
            end
            CMD_STOP: begin
              sda_level_next = 1'b0;
            end
            CMD_WRITE: begin
              shift_byte_next = op.data_byte;
              sda_level_next  = op.data_byte[7];
            end
            CMD_READ: begin
              shift_byte_next = '0;
              sda_level_next  = 1'b1;
            end
            CMD_RACK: begin
              sda_level_next = 1'b1;
            end
            CMD_SACK: begin
              shift_byte_next = {7'd0, op.ack_to_send};
              sda_level_next  = op.ack_to_send;
            end
            default: begin
              active_cmd_next = CMD_IDLE;
            end
          endcase
        end
      end else if (op.cls == CLS_TICK) begin
        hold_cnt_next = cnt_dec;
        if (cnt_dec == '0) begin
          // Sample SDA at the end of an SCL-high hold
          if (active_cmd == CMD_READ && step_idx[0]) begin
            shift_byte_next = {shift_byte[6:0], op.sda_in};
          end
          if (active_cmd == CMD_RACK && step_idx == 5'd1) begin
            ack_bit_next = op.sda_in;
          end
          // Advance the step and its bit/phase position
          step_idx_next = step_inc;
          if (phase == 2'd2) begin
            phase_next   = '0;
            bit_idx_next = bit_idx + 3'd1;
          end else begin
            phase_next = phase + 2'd1;
          end
          if (step_inc >= step_total(active_cmd)) begin
            if (active_cmd == CMD_READ) begin
              rx_byte_q_next = shift_byte_next;
            end
            active_cmd_next = CMD_IDLE;
            step_idx_next   = '0;
            done            = 1'b1;
          end else begin
            hold_cnt_next = hold_load;
            // Apply the pin change of the new step
            unique case (active_cmd)
              CMD_START: begin
                if (step_inc == 5'd1) begin
                  scl_level_next = 1'b1;
                end else if (step_inc == 5'd2) begin
                  sda_level_next = 1'b0;
                end else begin
                  scl_level_next = 1'b0;
                end
              end
              CMD_STOP: begin
                if (step_inc == 5'd1) begin
                  scl_level_next = 1'b1;
                end else begin
                  sda_level_next = 1'b1;
                end
              end
              CMD_WRITE: begin
                if (phase_next == 2'd0) begin
                  sda_level_next = shift_byte[3'd7 - bit_idx_next];
                end else if (phase_next == 2'd1) begin
                  scl_level_next = 1'b1;
                end else begin
                  scl_level_next = 1'b0;
                end
              end
              CMD_READ: begin
                scl_level_next = step_inc[0];
              end
              CMD_RACK, CMD_SACK: begin
                scl_level_next = (step_inc == 5'd1);
              end
              default: begin
                scl_level_next = scl_level;
              end
            endcase
          end
        end
      end
    end
  end

  // Build the result word from the updated state
  always_comb begin
    res_in.scl_out  = scl_level_next;
    res_in.sda_out  = sda_level_next;
    res_in.busy_res = (active_cmd_next != CMD_IDLE);
    res_in.done_res = done;
    res_in.rx_byte  = rx_byte_q_next;
    res_in.ack_seen = ack_bit_next;
  end

  // Sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      active_cmd <= CMD_IDLE;
      step_idx   <= '0;
      phase      <= '0;
      bit_idx    <= '0;
      hold_cnt   <= '0;
      shift_byte <= '0;
      rx_byte_q  <= '0;
      ack_bit    <= 1'b0;
    end else begin
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      active_cmd <= active_cmd_next;
      step_idx   <= step_idx_next;
      phase      <= phase_next;
      bit_idx    <= bit_idx_next;
      hold_cnt   <= hold_cnt_next;
      shift_byte <= shift_byte_next;
      rx_byte_q  <= rx_byte_q_next;
      ack_bit    <= ack_bit_next;
    end
  end

  // Hold results until the consumer pops them
  i2cms_queue #(
    .word_t(out_word_t)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (take),
    .full (res_full),
    .wdata(res_in),
    .pop  (res_pop),
    .empty(res_empty),
    .rdata(res)
  );

  `ASSERT_IMP(a_active_hold, clk, rst, active_cmd != CMD_IDLE, |hold_cnt)
  `ASSERT_IMP(a_step_range, clk, rst, active_cmd != CMD_IDLE, step_idx < step_total(active_cmd))
  `ASSERT_IMP(a_write_pos, clk, rst, active_cmd == CMD_WRITE, step_idx == 5'(3 * bit_idx + phase))
  `ASSERT_NXT(a_done_idle, clk, rst, take && done, active_cmd == CMD_IDLE)

endmodule

// ===== rtl/i2c_master_line_sequencer.sv =====
// I2C master line sequencer: takes one command or tick word per cycle unless
// the input queue is full, and returns one result word per input word with
// the SCL/SDA drive levels and status. Words pass through a two-entry input
// queue, a combinational sequencer step and a two-entry result queue, so a
// new word is accepted every cycle while results are popped; a word is
// registered in the input queue and its result in the result queue before
// the result is on the result ports. Each pin change is held for hold_ticks
// tick words (zero counts as one); hold_ticks is written over the APB port at
// address 0.
module i2c_master_line_sequencer #(
  parameter int HOLD_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // input word queue side
  input  logic                 push,
  output logic                 full,
  input  i2cms_pkg::in_word_t  item,
  // result word queue side
  output logic                 empty,
  input  logic                 pop,
  output i2cms_pkg::out_word_t result,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import i2cms_pkg::*;

  logic [CFG_WIDTH-1:0] hold_ticks;
  logic                 cfg_write;
  op_word_t             op;
  logic                 op_empty;
  logic                 op_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Write the hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RESET;
    end else if (cfg_write && paddr == REG_HOLD_TICKS) begin
      hold_ticks <= pwdata[CFG_WIDTH-1:0];
    end
  end

  // Read back the hold register
  assign prdata = (paddr == REG_HOLD_TICKS) ? 32'(hold_ticks) : '0;

  i2cms_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .op      (op),
    .op_empty(op_empty),
    .op_pop  (op_pop)
  );

  i2cms_back #(
    .HOLD_WIDTH(HOLD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .hold_ticks(hold_ticks),
    .op        (op),
    .op_empty  (op_empty),
    .op_pop    (op_pop),
    .res       (result),
    .res_empty (empty),
    .res_pop   (pop)
  );

endmodule
